[design/cs3_pkg.sv]
// ----------------------------------------------------------------------------
// cs3_pkg
// Widths, latencies and payload types shared by the 3x3 Cramer solver.
// ----------------------------------------------------------------------------
package cs3_pkg;

   localparam int IN_W  = 16;              // input element width, Q8.8
   localparam int OFB   = 16;              // fraction bits of the solution
   localparam int QW    = 32;              // solution width
   localparam int PW1   = 2 * IN_W;        // 2x2 minor product
   localparam int CW    = PW1 + 1;         // cofactor
   localparam int PW2   = IN_W + CW;       // element times cofactor
   localparam int DW    = PW2 + 2;         // sum of three terms
   localparam int RW    = DW + 1;          // divider partial remainder
   localparam int NW    = DW + OFB;        // scaled dividend
   localparam int LAT_DET = 4;             // determinant pipeline depth
   localparam int LAT_DIV = QW + 1;        // divider pipeline depth
   localparam int REQ_W = 12 * IN_W;
   localparam int RSP_W = ((3 * QW + 2 + 7) / 8) * 8;

   typedef logic signed [IN_W-1:0] elem_type;
   typedef logic signed [DW-1:0]   det_type;

endpackage

[design/cs3_det.sv]
// ----------------------------------------------------------------------------
// cs3_det
// Exact 3x3 determinant as r0 . (r1 x r2), four register stages.
// ----------------------------------------------------------------------------
module cs3_det (
   input  logic              clock,
   input  logic              en,
   input  cs3_pkg::elem_type r0 [3],
   input  cs3_pkg::elem_type r1 [3],
   input  cs3_pkg::elem_type r2 [3],
   output cs3_pkg::det_type  det
);
   import cs3_pkg::*;

   logic signed [PW1-1:0] p_ff [6];
   logic signed [CW-1:0]  c_ff [3];
   logic signed [PW2-1:0] m_ff [3];
   elem_type              ra_ff [3];
   elem_type              rb_ff [3];
   det_type               det_ff;

   // stage 1: minor products, stage 2: cofactors
   // stage 3: weight by row 0, stage 4: sum
   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= r1[1] * r2[2];
         p_ff[1] <= r1[2] * r2[1];
         p_ff[2] <= r1[2] * r2[0];
         p_ff[3] <= r1[0] * r2[2];
         p_ff[4] <= r1[0] * r2[1];
         p_ff[5] <= r1[1] * r2[0];
         ra_ff   <= r0;
         for (int k = 0; k < 3; k++) begin
            c_ff[k] <= CW'(p_ff[2*k]) - CW'(p_ff[2*k+1]);
         end
         rb_ff <= ra_ff;
         for (int k = 0; k < 3; k++) begin
            m_ff[k] <= PW2'(rb_ff[k]) * PW2'(c_ff[k]);
         end
         det_ff <= DW'(m_ff[0]) + DW'(m_ff[1]) + DW'(m_ff[2]);
      end
   end

   assign det = det_ff;

endmodule

[design/cs3_div.sv]
// ----------------------------------------------------------------------------
// cs3_div
// Pipelined restoring divider: |num| * 2^OFB / |den|, one quotient bit per
// stage, with an overflow flag when the quotient needs more than QW bits.
// ----------------------------------------------------------------------------
module cs3_div (
   input  logic             clock,
   input  logic             en,
   input  cs3_pkg::det_type num,
   input  cs3_pkg::det_type den,
   output logic [cs3_pkg::QW-1:0] quo,
   output logic             neg,
   output logic             big
);
   import cs3_pkg::*;

   logic [RW-1:0] rem_ff [QW+1];
   logic [QW-1:0] low_ff [QW+1];
   logic [QW-1:0] q_ff   [QW+1];
   logic [DW-1:0] d_ff   [QW+1];
   logic          neg_ff [QW+1];
   logic          big_ff [QW+1];

   logic [DW-1:0] n_abs, d_abs;
   logic [NW-1:0] nsh;

   // take magnitudes and align the dividend
   always_comb begin
      n_abs = num[DW-1] ? DW'(-num) : DW'(num);
      d_abs = den[DW-1] ? DW'(-den) : DW'(den);
      nsh   = {n_abs, {OFB{1'b0}}};
   end

   // prep stage: the quotient overflows when the top part already reaches d
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(nsh[NW-1:QW]);
         low_ff[0] <= nsh[QW-1:0];
         q_ff[0]   <= '0;
         d_ff[0]   <= d_abs;
         neg_ff[0] <= num[DW-1] ^ den[DW-1];
         big_ff[0] <= DW'(nsh[NW-1:QW]) >= d_abs;
      end
   end

   // one compare and subtract per stage
   for (genvar i = 1; i <= QW; i++) begin : g_step
      logic [RW-1:0] sh;
      logic          ge;
      assign sh = {rem_ff[i-1][DW-1:0], low_ff[i-1][QW-1]};
      assign ge = sh >= {1'b0, d_ff[i-1]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= ge ? sh - {1'b0, d_ff[i-1]} : sh;
            low_ff[i] <= {low_ff[i-1][QW-2:0], 1'b0};
            q_ff[i]   <= {q_ff[i-1][QW-2:0], ge};
            d_ff[i]   <= d_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
            big_ff[i] <= big_ff[i-1];
         end
      end
   end

   assign quo = q_ff[QW];
   assign neg = neg_ff[QW];
   assign big = big_ff[QW];

endmodule

[design/cramer_solve_3x3.sv]
// ----------------------------------------------------------------------------
// cramer_solve_3x3
// Solves A x = b by Cramer's rule: four exact determinants, three pipelined
// dividers, truncated and saturated Q16.16 results.
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  req_tdata  m00..m22, rhs0..rhs2
//  rsp      out  rsp_tvalid/rsp_tready  rsp_tdata  sol_x, sol_y, sol_z, flags
//
// One system per cycle while rsp is not stalled. Reset clears only the valid
// bits. A stall on rsp freezes the whole pipeline; req_tready follows the
// output register.
// ----------------------------------------------------------------------------
module cramer_solve_3x3 (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // m00 m01 m02 m10 m11 m12 m20 m21 m22 rhs0 rhs1 rhs2, 16 bits each
   input  logic [cs3_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // sol_x[31:0] sol_y[63:32] sol_z[95:64] singular[96] saturated[97], zeros
   output logic [cs3_pkg::RSP_W-1:0]  rsp_tdata
);
   import cs3_pkg::*;

   localparam int LAT = LAT_DET + LAT_DIV;

   logic     en;
   elem_type a [9];
   elem_type b [3];
   elem_type ra [3][3], rx [3][3], ry [3][3], rz [3][3];
   det_type  det_a, det_x, det_y, det_z;
   logic [QW-1:0] quo [3];
   logic          neg [3], big [3];
   logic [LAT-1:0]     vld_ff;
   logic [LAT_DIV-1:0] sing_ff;
   logic               out_vld_ff;
   logic [QW-1:0]      sol_ff [3];
   logic               sing_out_ff, sat_out_ff;
   logic [QW-1:0]      sol_in [3];
   logic               sat_in;

   // advance everything while the output register can take a result
   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = en;

   // unpack and build the four matrices
   always_comb begin
      for (int k = 0; k < 9; k++) a[k] = req_tdata[k*IN_W +: IN_W];
      for (int k = 0; k < 3; k++) b[k] = req_tdata[(9+k)*IN_W +: IN_W];
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            ra[i][j] = a[i*3+j];
            rx[i][j] = (j == 0) ? b[i] : a[i*3+j];
            ry[i][j] = (j == 1) ? b[i] : a[i*3+j];
            rz[i][j] = (j == 2) ? b[i] : a[i*3+j];
         end
      end
   end

   cs3_det u_det_a (.clock, .en, .r0(ra[0]), .r1(ra[1]), .r2(ra[2]), .det(det_a));
   cs3_det u_det_x (.clock, .en, .r0(rx[0]), .r1(rx[1]), .r2(rx[2]), .det(det_x));
   cs3_det u_det_y (.clock, .en, .r0(ry[0]), .r1(ry[1]), .r2(ry[2]), .det(det_y));
   cs3_det u_det_z (.clock, .en, .r0(rz[0]), .r1(rz[1]), .r2(rz[2]), .det(det_z));

   cs3_div u_div_x (.clock, .en, .num(det_x), .den(det_a),
                    .quo(quo[0]), .neg(neg[0]), .big(big[0]));
   cs3_div u_div_y (.clock, .en, .num(det_y), .den(det_a),
                    .quo(quo[1]), .neg(neg[1]), .big(big[1]));
   cs3_div u_div_z (.clock, .en, .num(det_z), .den(det_a),
                    .quo(quo[2]), .neg(neg[2]), .big(big[2]));

   // carry valid bits and the singular flag beside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff     <= {vld_ff[LAT-2:0], req_tvalid};
         out_vld_ff <= vld_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sing_ff <= {sing_ff[LAT_DIV-2:0], det_a == '0};
      end
   end

   // sign and clip the quotients
   always_comb begin
      sat_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (neg[k]) begin
            if (big[k] || quo[k] > {1'b1, {(QW-1){1'b0}}}) begin
               sol_in[k] = {1'b1, {(QW-1){1'b0}}};
               sat_in    = 1'b1;
            end else begin
               sol_in[k] = -quo[k];
            end
         end else begin
            if (big[k] || quo[k][QW-1]) begin
               sol_in[k] = {1'b0, {(QW-1){1'b1}}};
               sat_in    = 1'b1;
            end else begin
               sol_in[k] = quo[k];
            end
         end
      end
   end

   // output register; a singular system gives zeros
   always_ff @(posedge clock) begin
      if (en) begin
         sing_out_ff <= sing_ff[LAT_DIV-1];
         sat_out_ff  <= sat_in && !sing_ff[LAT_DIV-1];
         for (int k = 0; k < 3; k++) begin
            sol_ff[k] <= sing_ff[LAT_DIV-1] ? '0 : sol_in[k];
         end
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_W'({sat_out_ff, sing_out_ff, sol_ff[2], sol_ff[1], sol_ff[0]});

   // a singular result carries zeros and no clip
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[3*QW] |-> rsp_tdata[3*QW-1:0] == '0 && !rsp_tdata[3*QW+1])
      else $error("singular result not zeroed");

   // the pipeline moves exactly when the output register frees up
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("ready does not follow output register");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

[verif/cramer_solve_3x3_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cramer_solve_3x3_tb
// Streams 3x3 systems into the Cramer solver and checks every solution
// against an exact determinant-and-quotient calculation done here.
// ----------------------------------------------------------------------------
module cramer_solve_3x3_tb;
   import cs3_pkg::*;

   localparam int  DRAIN_CYCLES = 80;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic        saturated;
      logic        singular;
      logic [31:0] sol_z;
      logic [31:0] sol_y;
      logic [31:0] sol_x;
   } solution_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   logic [REQ_W-1:0] pending_systems[$];
   solution_type     expected_solutions[$];
   int     mismatch_count = 0;
   longint cycle_count = 0;
   bit     stimulus_done = 1'b0;
   bit     hold_sender = 1'b0;
   bit     quiet_tail = 1'b0;
   int     send_gap = 0;
   int     recv_gap = 0;
   bit     req_tready_seen = 1'b0;

   cramer_solve_3x3 DUT (.*);

   always #4 clock = ~clock;

   // Exact 3x3 determinant of rows a, b, c
   function automatic logic signed [127:0] det3(
      input logic signed [127:0] a0, a1, a2, b0, b1, b2, c0, c1, c2);
      det3 = a0 * (b1 * c2 - b2 * c1) + a1 * (b2 * c0 - b0 * c2)
           + a2 * (b0 * c1 - b1 * c0);
   endfunction

   // Truncated, saturated num * 2^16 / den
   function automatic logic [31:0] scaled_quotient(
      input logic signed [127:0] num, input logic signed [127:0] den,
      inout logic clipped);
      logic signed [127:0] q;
      q = (num <<< OFB) / den;
      if (q > 128'sd2147483647) begin
         clipped = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (q < -128'sd2147483648) begin
         clipped = 1'b1;
         return 32'h8000_0000;
      end
      return q[31:0];
   endfunction

   function automatic solution_type solve_system(input logic [REQ_W-1:0] sys);
      logic signed [127:0] e[12];
      logic signed [127:0] d;
      solution_type s;
      logic clipped;
      for (int i = 0; i < 12; i++) e[i] = $signed(sys[i*IN_W +: IN_W]);
      d = det3(e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]);
      s = '0;
      clipped = 1'b0;
      if (d == 0) begin
         s.singular = 1'b1;
         return s;
      end
      s.sol_x = scaled_quotient(det3(e[9], e[1], e[2], e[10], e[4], e[5],
                                     e[11], e[7], e[8]), d, clipped);
      s.sol_y = scaled_quotient(det3(e[0], e[9], e[2], e[3], e[10], e[5],
                                     e[6], e[11], e[8]), d, clipped);
      s.sol_z = scaled_quotient(det3(e[0], e[1], e[9], e[3], e[4], e[10],
                                     e[6], e[7], e[11]), d, clipped);
      s.saturated = clipped;
      return s;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("cycle %0d: %s got %h want %h", cycle_count, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [IN_W-1:0] rand_elem();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return IN_W'($urandom_range(0, 8) - 4);
         4: return 16'h0100;
         5: return IN_W'($urandom_range(0, 512) - 256);
         default: return IN_W'($urandom);
      endcase
   endfunction

   function automatic logic [REQ_W-1:0] build_system(input int kind);
      logic [REQ_W-1:0] sys;
      for (int i = 0; i < 12; i++) sys[i*IN_W +: IN_W] = rand_elem();
      case (kind)
         // singular: row 2 copies row 0 or a column goes to zero
         0: sys[6*IN_W +: 3*IN_W] = sys[0 +: 3*IN_W];
         1: for (int r = 0; r < 3; r++) sys[(r*3+1)*IN_W +: IN_W] = '0;
         // tiny diagonal, random rhs
         2: begin
            sys[0 +: 9*IN_W] = '0;
            for (int r = 0; r < 3; r++)
               sys[(r*4)*IN_W +: IN_W] = IN_W'($urandom_range(1, 2));
         end
         default: ;
      endcase
      return sys;
   endfunction

   function automatic logic [REQ_W-1:0] diag_system(
      input logic [IN_W-1:0] dv, input logic [IN_W-1:0] bv);
      logic [REQ_W-1:0] sys;
      sys = '0;
      for (int r = 0; r < 3; r++) begin
         sys[(r*4)*IN_W +: IN_W] = dv;
         sys[(9+r)*IN_W +: IN_W] = bv;
      end
      return sys;
   endfunction

   // Stimulus: directed cases, then random systems
   initial begin
      pending_systems.push_back('0);
      pending_systems.push_back(diag_system(16'h0100, 16'h0100));
      pending_systems.push_back(diag_system(16'h0001, 16'h7FFF));
      pending_systems.push_back(diag_system(16'h0001, 16'h8000));
      pending_systems.push_back(diag_system(16'h7FFF, 16'h8000));
      pending_systems.push_back(diag_system(16'h8000, 16'h7FFF));
      pending_systems.push_back(diag_system(16'h0100, 16'h8000));
      pending_systems.push_back(diag_system(16'h0080, 16'h8000));
      pending_systems.push_back(diag_system(16'hFFFF, 16'h0000));
      pending_systems.push_back({12{16'h7FFF}});
      pending_systems.push_back({12{16'h8000}});
      pending_systems.push_back({12{16'hFFFF}});
      for (int k = 0; k < 8; k++) pending_systems.push_back(build_system(k % 4));
      for (int n = 0; n < 1330; n++) begin
         if (n == 600) begin
            wait (pending_systems.size() == 0 && !req_tvalid);
            hold_sender = 1'b1;
            wait (expected_solutions.size() == 0);
            hold_sender = 1'b0;
         end
         if (n == 1150) quiet_tail = 1'b1;
         pending_systems.push_back(build_system($urandom_range(0, 9)));
      end
      stimulus_done = 1'b1;
   end

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Driver: present systems at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready_seen) begin
            expected_solutions.push_back(solve_system(req_tdata));
         end
         if (!(req_tvalid && !req_tready_seen)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 19) == 0) begin
               send_gap = $urandom_range(1, 14);
               req_tvalid <= 1'b0;
            end else if (!hold_sender && pending_systems.size() > 0) begin
               req_tdata  <= pending_systems.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         // Receiver backpressure
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 19) == 0) begin
            recv_gap = $urandom_range(1, 14);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Sample the request handshake at the rising edge for the driver
   always @(posedge clock) req_tready_seen <= req_tready;

   // Monitor: check each solution transaction
   always @(posedge clock) begin
      solution_type got, want;
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[$bits(solution_type)-1:0];
         if (expected_solutions.size() == 0) begin
            report_mismatch("unexpected solution", got.sol_x, 32'h0);
         end else begin
            want = expected_solutions.pop_front();
            if (got.sol_x !== want.sol_x) report_mismatch("sol_x", got.sol_x, want.sol_x);
            if (got.sol_y !== want.sol_y) report_mismatch("sol_y", got.sol_y, want.sol_y);
            if (got.sol_z !== want.sol_z) report_mismatch("sol_z", got.sol_z, want.sol_z);
            if (got.singular !== want.singular)
               report_mismatch("singular", 32'(got.singular), 32'(want.singular));
            if (got.saturated !== want.saturated)
               report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
         end
      end
   end

   // End of run
   initial begin
      wait (stimulus_done && pending_systems.size() == 0);
      @(negedge clock);
      @(negedge clock);
      wait (!req_tvalid && expected_solutions.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_solutions.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Timeout
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

endmodule
